// File: rtl/core/ies_pkg.sv
// types, constants and codes shared by the irrigation event scheduler
// depends on nothing; used by ies_ctrl, ies_dpath and the top level
package ies_pkg;

    localparam int NUM_EVENTS_DEF = 16;
    localparam int NUM_ZONES_DEF  = 32;
    localparam int MAX_RESULTS    = 32;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam int SEC_PER_MIN    = 60;
    localparam int LIMIT_SEC      = 99 * 60;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_ZONE_ON  = 2'd2,
        CMD_ZONE_OFF = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_LIM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  event_index;
        logic [4:0]  zone;
        logic        active;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [6:0]  run_minutes;
        logic [6:0]  day_mask;
        logic [2:0]  weekday;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [4:0] zone_number;
        logic       turn_on;
        logic [3:0] source_event;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [4:0] zone;
        logic       active;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [6:0] run_minutes;
        logic [6:0] day_mask;
    } t_event;

    typedef struct packed {
        logic load_tick;
        logic write_evt;
        logic manual;
        logic eval;
        logic emit_lim;
        logic flush;
    } t_ctrl_cmd;

    typedef struct packed {
        logic lim_req;
        logic idx_last;
    } t_ctrl_sts;

endpackage

// File: rtl/core/ies_ctrl.sv
// controller state machine of the irrigation event scheduler
// depends on ies_pkg; drives ies_dpath through t_ctrl_cmd, reads t_ctrl_sts
module ies_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ies_pkg::t_cmd     i_cmd,
    input  ies_pkg::t_ctrl_sts i_sts,
    output ies_pkg::t_ctrl_cmd o_ctl,
    output logic              o_busy
);

    ies_pkg::t_state r_state;
    ies_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ies_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ies_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        ies_pkg::CMD_TICK:     n_state = ies_pkg::S_EVAL;
                        ies_pkg::CMD_WRITE:    n_state = ies_pkg::S_IDLE;
                        ies_pkg::CMD_ZONE_ON,
                        ies_pkg::CMD_ZONE_OFF: n_state = ies_pkg::S_FIN;
                    endcase
                end
            end
            ies_pkg::S_EVAL: begin
                priority if (i_sts.lim_req) begin
                    n_state = ies_pkg::S_LIM;
                end else if (i_sts.idx_last) begin
                    n_state = ies_pkg::S_FIN;
                end else begin
                    n_state = ies_pkg::S_EVAL;
                end
            end
            ies_pkg::S_LIM: begin
                n_state = i_sts.idx_last ? ies_pkg::S_FIN : ies_pkg::S_EVAL;
            end
            ies_pkg::S_FIN: begin
                n_state = ies_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            ies_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        ies_pkg::CMD_TICK:     o_ctl.load_tick = 1'b1;
                        ies_pkg::CMD_WRITE:    o_ctl.write_evt = 1'b1;
                        ies_pkg::CMD_ZONE_ON,
                        ies_pkg::CMD_ZONE_OFF: o_ctl.manual    = 1'b1;
                    endcase
                end
            end
            ies_pkg::S_EVAL: o_ctl.eval     = 1'b1;
            ies_pkg::S_LIM:  o_ctl.emit_lim = 1'b1;
            ies_pkg::S_FIN:  o_ctl.flush    = 1'b1;
        endcase
    end

    assign o_busy = (r_state != ies_pkg::S_IDLE);

endmodule

// File: rtl/core/ies_dpath.sv
// datapath of the irrigation event scheduler: event and start time memories,
// running and forced flags, per-event checks and the result pending/output stage
// depends on ies_pkg; commanded by ies_ctrl
module ies_dpath #(
    parameter int NUM_EVENTS = ies_pkg::NUM_EVENTS_DEF,
    parameter int NUM_ZONES  = ies_pkg::NUM_ZONES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ies_pkg::t_in_item   i_item,
    input  ies_pkg::t_ctrl_cmd  i_ctl,
    output ies_pkg::t_ctrl_sts  o_sts,
    output logic                o_valid,
    output ies_pkg::t_out_item  o_result
);

    localparam int EIDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int ZIDX_W = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int CNT_W  = ies_pkg::CNT_W;

    // storage
    ies_pkg::t_event       r_evt_mem [NUM_EVENTS];
    logic [31:0]           r_st_mem  [NUM_EVENTS];
    logic [NUM_EVENTS-1:0] r_evt_vld;
    logic [NUM_EVENTS-1:0] r_st_vld;
    logic [NUM_EVENTS-1:0] r_running;
    logic [NUM_ZONES-1:0]  r_forced;

    // walk state
    logic [EIDX_W-1:0]     r_idx;
    ies_pkg::t_event       r_rd_evt;
    logic                  r_rd_evt_vld;
    logic [31:0]           r_rd_st;
    logic                  r_rd_st_vld;
    logic [2:0]            r_wd;
    logic [4:0]            r_hr;
    logic [5:0]            r_mn;
    logic [31:0]           r_now;
    logic [4:0]            r_lim_zone;

    // result stage
    logic                  r_pend_vld;
    ies_pkg::t_out_item    r_pend;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_vld;
    ies_pkg::t_out_item    r_out;

    logic                  wr_ok;
    logic [EIDX_W-1:0]     wr_addr;
    logic                  man_ok;
    logic [ZIDX_W-1:0]     man_zidx;
    logic                  rd_en;
    logic [EIDX_W-1:0]     rd_addr;
    logic                  idx_last;
    logic                  idx_adv;
    ies_pkg::t_event       ev;
    logic [31:0]           ev_st;
    logic                  ev_zone_ok;
    logic [ZIDX_W-1:0]     ev_zidx;
    logic                  forced_now;
    logic                  run_now;
    logic [7:0]            days_ext;
    logic                  day_ok;
    logic [12:0]           run_sec;
    logic [32:0]           now_x;
    logic [32:0]           stop_at;
    logic [32:0]           lim_at;
    logic                  ev_start;
    logic                  ev_stop;
    logic                  ev_lim;
    logic                  push_vld;
    ies_pkg::t_out_item    push_item;
    logic                  push_ok;

    assign wr_ok    = int'(i_item.event_index) < NUM_EVENTS;
    assign wr_addr  = EIDX_W'(i_item.event_index);
    assign man_ok   = int'(i_item.zone) < NUM_ZONES;
    assign man_zidx = ZIDX_W'(i_item.zone);

    assign idx_last = (r_idx == EIDX_W'(NUM_EVENTS - 1));
    assign rd_en    = i_ctl.load_tick || (i_ctl.eval && !idx_last);
    assign rd_addr  = i_ctl.load_tick ? '0 : r_idx + EIDX_W'(1);

    // entries never written read as zero
    assign ev    = r_rd_evt_vld ? r_rd_evt : '0;
    assign ev_st = r_rd_st_vld ? r_rd_st : '0;

    assign ev_zone_ok = int'(ev.zone) < NUM_ZONES;
    assign ev_zidx    = ZIDX_W'(ev.zone);
    assign forced_now = ev_zone_ok && r_forced[ev_zidx];
    assign run_now    = r_running[r_idx];
    assign days_ext   = {1'b0, ev.day_mask};
    assign day_ok     = days_ext[r_wd];

    assign run_sec = 13'(ev.run_minutes) * 13'(ies_pkg::SEC_PER_MIN);
    assign now_x   = {1'b0, r_now};
    assign stop_at = {1'b0, ev_st} + 33'(run_sec);
    assign lim_at  = {1'b0, ev_st} + 33'(ies_pkg::LIMIT_SEC);

    // a start sets the start time to now, so neither stop can fire with it
    assign ev_start = ev.active && !run_now && day_ok &&
                      (ev.start_hour == r_hr) && (ev.start_minute == r_mn);
    assign ev_stop  = run_now && (now_x > stop_at);
    assign ev_lim   = !ev_start && ((run_now && !ev_stop) || forced_now) &&
                      (now_x > lim_at);

    assign idx_adv = ((i_ctl.eval && !ev_lim) || i_ctl.emit_lim) && !idx_last;

    assign o_sts.lim_req  = ev_lim;
    assign o_sts.idx_last = idx_last;

    always_comb begin
        push_vld  = 1'b0;
        push_item = '0;
        unique if (i_ctl.manual) begin
            push_vld               = man_ok;
            push_item.zone_number  = i_item.zone;
            push_item.turn_on      = (i_item.cmd == ies_pkg::CMD_ZONE_ON);
        end else if (i_ctl.eval) begin
            push_vld               = ev_start || ev_stop;
            push_item.zone_number  = ev.zone;
            push_item.turn_on      = ev_start;
            push_item.source_event = 4'(r_idx);
        end else if (i_ctl.emit_lim) begin
            push_vld               = 1'b1;
            push_item.zone_number  = r_lim_zone;
            push_item.source_event = 4'(r_idx);
        end else begin
            push_vld = 1'b0;
        end
    end

    assign push_ok = push_vld && (r_cnt < CNT_W'(ies_pkg::MAX_RESULTS));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_vld    <= '0;
            r_st_vld     <= '0;
            r_running    <= '0;
            r_forced     <= '0;
            r_idx        <= '0;
            r_rd_evt_vld <= 1'b0;
            r_rd_st_vld  <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_cnt        <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_out_vld <= r_pend_vld && (push_ok || i_ctl.flush);
            if (i_ctl.write_evt && wr_ok) begin
                r_evt_vld[wr_addr] <= 1'b1;
            end
            if (i_ctl.manual && man_ok) begin
                r_forced[man_zidx] <= (i_item.cmd == ies_pkg::CMD_ZONE_ON);
            end
            if (i_ctl.load_tick) begin
                r_idx <= '0;
            end else if (idx_adv) begin
                r_idx <= r_idx + EIDX_W'(1);
            end
            if (rd_en) begin
                r_rd_evt_vld <= r_evt_vld[rd_addr];
                r_rd_st_vld  <= r_st_vld[rd_addr];
            end
            if (i_ctl.eval) begin
                r_running[r_idx] <= ev_start || (run_now && !ev_stop && !ev_lim);
                if (ev_start) begin
                    r_st_vld[r_idx] <= 1'b1;
                end
                if (ev_lim && ev_zone_ok) begin
                    r_forced[ev_zidx] <= 1'b0;
                end
            end
            if (push_ok) begin
                r_pend_vld <= 1'b1;
                r_cnt      <= r_cnt + CNT_W'(1);
            end else if (i_ctl.flush) begin
                r_pend_vld <= 1'b0;
                r_cnt      <= '0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.write_evt && wr_ok) begin
            r_evt_mem[wr_addr] <= '{zone:         i_item.zone,
                                    active:       i_item.active,
                                    start_hour:   i_item.start_hour,
                                    start_minute: i_item.start_minute,
                                    run_minutes:  i_item.run_minutes,
                                    day_mask:     i_item.day_mask};
        end
        if (i_ctl.eval && ev_start) begin
            r_st_mem[r_idx] <= r_now;
        end
        if (rd_en) begin
            r_rd_evt <= r_evt_mem[rd_addr];
            r_rd_st  <= r_st_mem[rd_addr];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_tick) begin
            r_wd  <= i_item.weekday;
            r_hr  <= i_item.hour_now;
            r_mn  <= i_item.minute_now;
            r_now <= i_item.now_seconds;
        end
        if (i_ctl.eval) begin
            r_lim_zone <= ev.zone;
        end
        if (push_ok) begin
            r_pend <= push_item;
            if (r_pend_vld) begin
                r_out <= r_pend;
            end
        end else if (i_ctl.flush && r_pend_vld) begin
            r_out <= '{zone_number:  r_pend.zone_number,
                       turn_on:      r_pend.turn_on,
                       source_event: r_pend.source_event,
                       last:         1'b1};
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// File: rtl/core/irrigation_event_scheduler_unit.sv
// top level of the irrigation event scheduler
// depends on ies_pkg, ies_ctrl and ies_dpath
//
// Commands are taken when start is high and busy is low. A table write leaves
// busy low. A manual zone command is accepted and then passes through the
// final state. A check tick passes through the accept step, an evaluation of
// each event in turn through the shared compare unit, a limit close step for
// each event that hits the 99-minute limit on that tick, and the final step.
// Each beat waits in a one-entry stage and is registered onto o_valid when the
// next valve action is found or in the final cycle, so beats trail the check
// that made them and come at most one per cycle; the last beat of a command
// is flagged by last and shown as busy falls. There is no back pressure, so
// the receiver must take every beat. At most 32 beats are reported per command.
module irrigation_event_scheduler_unit #(
    parameter int NUM_EVENTS = ies_pkg::NUM_EVENTS_DEF,
    parameter int NUM_ZONES  = ies_pkg::NUM_ZONES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ies_pkg::t_in_item  i_item,
    output logic               o_valid,
    output ies_pkg::t_out_item o_result
);

    ies_pkg::t_ctrl_cmd ctl;
    ies_pkg::t_ctrl_sts sts;

    ies_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (ies_pkg::t_cmd'(i_item.cmd)),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    ies_dpath #(
        .NUM_EVENTS (NUM_EVENTS),
        .NUM_ZONES  (NUM_ZONES)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    // the last beat of a command leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last |-> !busy)
        else $error("last beat while busy");

    // earlier beats only come while the walk is still running
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("non-final beat while idle");

    // a manual command on a real zone gives exactly one final beat for that zone
    a_manual_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy &&
        (i_item.cmd == ies_pkg::CMD_ZONE_ON || i_item.cmd == ies_pkg::CMD_ZONE_OFF) &&
        (int'(i_item.zone) < NUM_ZONES)
        |-> ##2 (o_valid && o_result.last && o_result.zone_number == $past(i_item.zone, 2)))
        else $error("manual command beat missing");
`endif

endmodule

// File: dv/tb_top.sv
// testbench for irrigation_event_scheduler_unit: a directed command table, then random commands
// every accepted command is run through a local schedule predictor and each result beat is
// checked in order; depends on ies_pkg and irrigation_event_scheduler_unit
module tb_top;
    import ies_pkg::*;

    localparam int N_RAND   = 430;
    localparam int WD_LIMIT = 2000;
    localparam int DRAIN    = 40;

    typedef struct {
        t_in_item  item;
        bit        typed;
        bit        has_act;
        t_out_item act;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_valid;
    t_in_item  i_item;
    t_out_item o_result;

    // expectation typed into the directed table travels with the command
    bit        row_typed;
    bit        row_has_act;
    t_out_item row_act;

    t_event      evt_tbl [NUM_EVENTS_DEF];
    bit          evt_run [NUM_EVENTS_DEF];
    logic [31:0] evt_t0 [NUM_EVENTS_DEF];
    bit          zone_force [NUM_ZONES_DEF];
    t_out_item   step_acts [$];
    t_out_item   exp_valve_q [$];
    t_row        dir_rows [$];

    int err_cnt    = 0;
    int cmd_cnt    = 0;
    int tick_cnt   = 0;
    int act_cnt    = 0;
    int idle_cnt   = 0;
    int burst_left = 0;

    // wall clock that the well-formed random commands follow
    logic [2:0]  sim_day;
    int          sim_mod;
    logic [31:0] sim_now;

    irrigation_event_scheduler_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_action(logic [4:0] z, logic on, logic [3:0] src);
        t_out_item a;
        a.zone_number  = z;
        a.turn_on      = on;
        a.source_event = src;
        a.last         = 1'b0;
        if (step_acts.size() < MAX_RESULTS) step_acts.push_back(a);
    endfunction

    function automatic void calc_valve_actions(t_in_item it);
        logic [63:0] now64;
        t_event      e;
        bit          day_ok;
        step_acts.delete();
        case (t_cmd'(it.cmd))
            CMD_WRITE: begin
                e.zone         = it.zone;
                e.active       = it.active;
                e.start_hour   = it.start_hour;
                e.start_minute = it.start_minute;
                e.run_minutes  = it.run_minutes;
                e.day_mask     = it.day_mask;
                evt_tbl[it.event_index] = e;
            end
            CMD_ZONE_ON, CMD_ZONE_OFF: begin
                zone_force[it.zone] = (it.cmd == CMD_ZONE_ON);
                add_action(it.zone, it.cmd == CMD_ZONE_ON, 4'd0);
            end
            default: begin
                now64 = {32'd0, it.now_seconds};
                for (int i = 0; i < NUM_EVENTS_DEF; i++) begin
                    e      = evt_tbl[i];
                    day_ok = (it.weekday < 3'd7) && e.day_mask[it.weekday];
                    if (e.active && !evt_run[i] && day_ok && e.start_hour == it.hour_now
                            && e.start_minute == it.minute_now) begin
                        add_action(e.zone, 1'b1, 4'(i));
                        evt_run[i] = 1'b1;
                        evt_t0[i]  = it.now_seconds;
                    end
                    if (evt_run[i] && now64 > 64'(evt_t0[i])
                            + 64'(e.run_minutes) * 64'(SEC_PER_MIN)) begin
                        add_action(e.zone, 1'b0, 4'(i));
                        evt_run[i] = 1'b0;
                    end
                    if ((evt_run[i] || zone_force[e.zone])
                            && now64 > 64'(evt_t0[i]) + 64'(LIMIT_SEC)) begin
                        add_action(e.zone, 1'b0, 4'(i));
                        evt_run[i]         = 1'b0;
                        zone_force[e.zone] = 1'b0;
                    end
                end
            end
        endcase
        if (step_acts.size() > 0) step_acts[step_acts.size() - 1].last = 1'b1;
    endfunction

    function automatic t_in_item mk_tick(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn,
                                         logic [31:0] now);
        t_in_item it;
        it            = '0;
        it.cmd        = CMD_TICK;
        it.weekday    = wd;
        it.hour_now   = hr;
        it.minute_now = mn;
        it.now_seconds = now;
        return it;
    endfunction

    function automatic t_in_item mk_write(logic [3:0] idx, logic [4:0] z, logic act,
                                          logic [4:0] hr, logic [5:0] mn, logic [6:0] run,
                                          logic [6:0] mask);
        t_in_item it;
        it              = '0;
        it.cmd          = CMD_WRITE;
        it.event_index  = idx;
        it.zone         = z;
        it.active       = act;
        it.start_hour   = hr;
        it.start_minute = mn;
        it.run_minutes  = run;
        it.day_mask     = mask;
        return it;
    endfunction

    function automatic t_in_item mk_manual(bit on, logic [4:0] z);
        t_in_item it;
        it      = '0;
        it.cmd  = on ? CMD_ZONE_ON : CMD_ZONE_OFF;
        it.zone = z;
        return it;
    endfunction

    function automatic void add_row(t_in_item it, bit typed, bit has_act, t_out_item act);
        t_row r;
        r.item    = it;
        r.typed   = typed;
        r.has_act = has_act;
        r.act     = act;
        dir_rows.push_back(r);
    endfunction

    function automatic t_in_item rand_cmd();
        t_in_item    it;
        logic [95:0] noise;
        int          pick;
        int          m;
        noise = {$urandom, $urandom, $urandom};
        it    = noise[$bits(t_in_item)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick < 55) begin
            if ($urandom_range(0, 49) == 0)
                sim_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                                      : $urandom;
            m       = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 150) : 1;
            sim_now = sim_now + 32'(m * 60);
            sim_mod = sim_mod + m;
            while (sim_mod >= 1440) begin
                sim_mod = sim_mod - 1440;
                sim_day = (sim_day == 3'd6) ? 3'd0 : sim_day + 3'd1;
            end
            it = mk_tick(sim_day, 5'(sim_mod / 60), 6'(sim_mod % 60), sim_now);
        end else if (pick < 75) begin
            m               = (sim_mod + $urandom_range(0, 4)) % 1440;
            it.cmd          = CMD_WRITE;
            it.active       = ($urandom_range(0, 4) != 0);
            it.start_hour   = 5'(m / 60);
            it.start_minute = 6'(m % 60);
            if ($urandom_range(0, 3) != 0) it.zone = 5'($urandom_range(0, 5));
            if ($urandom_range(0, 5) != 0) it.run_minutes = 7'($urandom_range(0, 15));
            if ($urandom_range(0, 3) != 0) it.day_mask = it.day_mask | 7'(1 << sim_day);
        end else if (pick < 88) begin
            it = mk_manual(1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0)
                           ? 5'($urandom_range(0, 5)) : noise[95:91]);
        end
        return it;
    endfunction

    task automatic drive_cmd(t_in_item it, bit typed, bit has_act, t_out_item act);
        i_item      <= it;
        row_typed   <= typed;
        row_has_act <= has_act;
        row_act     <= act;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid) begin
                act_cnt++;
                if (exp_valve_q.size() == 0) begin
                    $error("unexpected beat: zone_number %0d turn_on %0b source_event %0d",
                           o_result.zone_number, o_result.turn_on, o_result.source_event);
                    err_cnt++;
                end else begin
                    want = exp_valve_q.pop_front();
                    if (o_result.zone_number !== want.zone_number) begin
                        $error("zone_number expected %0d actual %0d",
                               want.zone_number, o_result.zone_number);
                        err_cnt++;
                    end
                    if (o_result.turn_on !== want.turn_on) begin
                        $error("turn_on expected %0b actual %0b", want.turn_on, o_result.turn_on);
                        err_cnt++;
                    end
                    if (o_result.source_event !== want.source_event) begin
                        $error("source_event expected %0d actual %0d",
                               want.source_event, o_result.source_event);
                        err_cnt++;
                    end
                    if (o_result.last !== want.last) begin
                        $error("last expected %0b actual %0b", want.last, o_result.last);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                cmd_cnt++;
                if (i_item.cmd == CMD_TICK) tick_cnt++;
                calc_valve_actions(i_item);
                if (row_typed) begin
                    if (row_has_act) exp_valve_q.push_back(row_act);
                end else begin
                    foreach (step_acts[k]) exp_valve_q.push_back(step_acts[k]);
                end
            end
            if (o_valid || (start && !busy)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= WD_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cnt, exp_valve_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_out_item none;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        row_typed   = 1'b0;
        row_has_act = 1'b0;
        row_act     = '0;
        none        = '0;
        sim_day     = 3'd0;
        sim_mod     = 360;
        sim_now     = 32'd86400;
        foreach (evt_tbl[i]) begin
            evt_tbl[i] = '0;
            evt_run[i] = 1'b0;
            evt_t0[i]  = '0;
        end
        foreach (zone_force[z]) zone_force[z] = 1'b0;

        // empty table after reset, manual extremes
        add_row(mk_tick(3'd0, 5'd0, 6'd0, 32'd0), 1'b1, 1'b0, none);
        add_row(mk_manual(1'b1, 5'd31), 1'b1, 1'b1, t_out_item'{5'd31, 1'b1, 4'd0, 1'b1});
        add_row(mk_manual(1'b0, 5'd0), 1'b1, 1'b1, t_out_item'{5'd0, 1'b0, 4'd0, 1'b1});
        add_row(mk_write(4'd0, 5'd3, 1'b1, 5'd6, 6'd30, 7'd10, 7'h7F), 1'b0, 1'b0, none);
        add_row(mk_write(4'd15, 5'd31, 1'b1, 5'd23, 6'd59, 7'd99, 7'h40), 1'b0, 1'b0, none);
        add_row(mk_write(4'd1, 5'd5, 1'b0, 5'd6, 6'd30, 7'd5, 7'h7F), 1'b0, 1'b0, none);
        // weekday seven, start, stop exactly at and just past run time
        add_row(mk_tick(3'd7, 5'd6, 6'd30, 32'd500), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd0, 5'd6, 6'd30, 32'd1000), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd0, 5'd6, 6'd40, 32'd1600), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd0, 5'd6, 6'd41, 32'd1601), 1'b0, 1'b0, none);
        // out-of-range time fields and longest run
        add_row(mk_write(4'd2, 5'd31, 1'b1, 5'd31, 6'd63, 7'd127, 7'h7F), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd6, 5'd31, 6'd63, 32'd2000), 1'b0, 1'b0, none);
        // forced zone hits the 99 minute limit with a stale start time
        add_row(mk_manual(1'b1, 5'd3), 1'b1, 1'b1, t_out_item'{5'd3, 1'b1, 4'd0, 1'b1});
        add_row(mk_tick(3'd1, 5'd8, 6'd0, 32'hFFFF_FFFF), 1'b0, 1'b0, none);
        // sums past 32 bits must not wrap
        add_row(mk_write(4'd0, 5'd3, 1'b1, 5'd23, 6'd59, 7'd10, 7'h7F), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd6, 5'd23, 6'd59, 32'hFFFF_FFF0), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd6, 5'd0, 6'd0, 32'hFFFF_FFFF), 1'b0, 1'b0, none);
        // zero run time
        add_row(mk_write(4'd3, 5'd0, 1'b1, 5'd12, 6'd0, 7'd0, 7'h01), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd0, 5'd12, 6'd0, 32'd100), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd0, 5'd12, 6'd1, 32'd101), 1'b0, 1'b0, none);
        add_row(mk_manual(1'b0, 5'd31), 1'b1, 1'b1, t_out_item'{5'd31, 1'b0, 4'd0, 1'b1});
        add_row(mk_write(4'd15, 5'd4, 1'b0, 5'd0, 6'd0, 7'd0, 7'h00), 1'b0, 1'b0, none);
        add_row(mk_tick(3'd2, 5'd9, 6'd0, 32'd9000), 1'b0, 1'b0, none);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            drive_cmd(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].has_act, dir_rows[k].act);
        repeat (N_RAND) drive_cmd(rand_cmd(), 1'b0, 1'b0, none);
        start <= 1'b0;

        while (exp_valve_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("run covered %0d commands (%0d check ticks, %0d from the directed table)",
                 cmd_cnt, tick_cnt, dir_rows.size());
        $display("%0d valve action beats compared, %0d mismatches", act_cnt, err_cnt);
        if (err_cnt == 0 && exp_valve_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: irrigation_event_scheduler_unit.f
rtl/core/ies_pkg.sv
rtl/core/ies_ctrl.sv
rtl/core/ies_dpath.sv
rtl/core/irrigation_event_scheduler_unit.sv
dv/tb_top.sv
